// ===== rtl/brmr_pkg.sv =====
// ----------------------------------------------------------------------------
// brmr_pkg: shared types and constants of the broadcast ring
// Operation and status codes, field widths and the result record that the
// reader control hands to the output pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package brmr_pkg;

    // Fixed field widths of the request and result items.
    localparam int DATA_W      = 32;
    localparam int MAX_READERS = 8;
    localparam int RD_W        = 3;   // reader id width
    localparam int ID_CNT_W    = 4;   // id counter, holds 0..MAX_READERS
    localparam int DROP_W      = 4;   // push count width

    // Stream widths: fields packed from bit 0 and padded to whole bytes.
    localparam int S_TDATA_RAW = RD_W + DATA_W;
    localparam int S_TDATA_W   = ((S_TDATA_RAW + 7) / 8) * 8;
    localparam int M_TDATA_RAW = DATA_W + RD_W + DROP_W;
    localparam int M_TDATA_W   = ((M_TDATA_RAW + 7) / 8) * 8;

    // Request kinds.
    typedef enum logic [1:0] {
        OP_WRITE = 2'd0,
        OP_READ  = 2'd1,
        OP_ADD   = 2'd2,
        OP_QUIT  = 2'd3
    } t_op;

    // Result status codes.
    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_EMPTY   = 3'd1,
        ST_QUIT    = 3'd2,
        ST_UNKNOWN = 3'd3,
        ST_FULL    = 3'd4
    } t_status;

    // Result of one request, apart from the word that comes from the ring.
    typedef struct packed {
        logic                rd_hit;      // the ring word is the data of this result
        t_status             status;
        logic [RD_W-1:0]     new_reader;
        logic [DROP_W-1:0]   dropped;
    } t_res;

endpackage : brmr_pkg

`default_nettype wire

// ===== rtl/broadcast_ring_multi_reader_core.sv =====
// ----------------------------------------------------------------------------
// broadcast_ring_multi_reader_core: one-writer, many-reader broadcast ring
// Top level with the request and result stream ports, the ring RAM and a
// two-stage result pipeline.
// ----------------------------------------------------------------------------
// Each request gives exactly one result. The block takes one request per
// clock cycle as long as results are taken; a result passes through stage
// one, which holds the decision while the registered ring RAM read completes,
// and then through the output register. The ring words live in a
// RING_DEPTH-entry RAM with one write and one read port; the write pointer,
// the eight reader pointers and their flags are registers compared in
// parallel on every write. Reader ids are given out from 0 and never reused.
// Ring entries need no clearing after reset; a reader only reaches written
// entries.
`default_nettype none

module broadcast_ring_multi_reader_core #(
    parameter int RING_DEPTH = 16
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    // Request stream.
    input  wire logic                             i_s_tvalid,
    output logic                                  o_s_tready,
    // tdata, from bit 0: reader (3), data_in (32), zero pad
    input  wire logic [brmr_pkg::S_TDATA_W-1:0]   i_s_tdata,
    // tuser: op (2)
    input  wire logic [1:0]                       i_s_tuser,
    // Result stream.
    output logic                                  o_m_tvalid,
    input  wire logic                             i_m_tready,
    // tdata, from bit 0: data_out (32), new_reader (3), dropped_readers (4), zero pad
    output logic [brmr_pkg::M_TDATA_W-1:0]        o_m_tdata,
    // tuser: status (3)
    output logic [2:0]                            o_m_tuser
);

    import brmr_pkg::*;

    localparam int PTR_W = $clog2(RING_DEPTH);

    logic              acc;
    logic              adv;
    t_op               req_op;
    logic [RD_W-1:0]   req_reader;
    logic [DATA_W-1:0] req_data;

    logic              wr_en, rd_en;
    logic [PTR_W-1:0]  wr_addr, rd_addr;
    logic [DATA_W-1:0] wr_data, rd_data;
    t_res              dec_res;

    logic              r_s1_vld;
    t_res              r_s1_res;
    logic              r_out_vld;
    t_res              r_out_res;
    logic [DATA_W-1:0] r_out_data;

    // Request unpacking.
    assign req_op     = t_op'(i_s_tuser);
    assign req_reader = i_s_tdata[RD_W-1:0];
    assign req_data   = i_s_tdata[RD_W +: DATA_W];

    // Handshake: stage one moves on when the output register is free.
    // No request is taken while reset is held.
    assign adv        = r_s1_vld && (!r_out_vld || i_m_tready);
    assign o_s_tready = i_rst_n && (!r_s1_vld || adv);
    assign acc        = i_s_tvalid && o_s_tready;

    brmr_ctrl #(
        .RING_DEPTH (RING_DEPTH)
    ) u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_acc     (acc),
        .i_op      (req_op),
        .i_reader  (req_reader),
        .i_data    (req_data),
        .o_wr_en   (wr_en),
        .o_wr_addr (wr_addr),
        .o_wr_data (wr_data),
        .o_rd_en   (rd_en),
        .o_rd_addr (rd_addr),
        .o_res     (dec_res)
    );

    brmr_ram #(
        .WIDTH (DATA_W),
        .DEPTH (RING_DEPTH)
    ) u_ring (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    // Stage one: decided result waits for the ring read data.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (acc) begin
            r_s1_vld <= 1'b1;
        end else if (adv) begin
            r_s1_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_s1_res <= dec_res;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (adv) begin
            r_out_vld <= 1'b1;
        end else if (i_m_tready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out_res  <= r_s1_res;
            r_out_data <= r_s1_res.rd_hit ? rd_data : '0;
        end
    end

    // Result packing.
    assign o_m_tvalid = r_out_vld;
    assign o_m_tuser  = r_out_res.status;
    assign o_m_tdata  = {{(M_TDATA_W - M_TDATA_RAW){1'b0}},
                         r_out_res.dropped, r_out_res.new_reader, r_out_data};

    // Stage one is never overwritten before it has moved on.
    a_s1_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_vld && !adv |-> !acc)
        else $error("stage one overwritten while stalled");

    // Only a successful read carries a word.
    a_data_only_on_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld && !r_out_res.rd_hit |-> r_out_data == '0)
        else $error("data on a result that is not a read");

    a_hit_is_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_vld && r_s1_res.rd_hit |-> r_s1_res.status == ST_OK)
        else $error("ring word attached to a failed request");

    // A loaded stage one reaches the output register at the next edge if free.
    a_s1_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv |=> r_out_vld)
        else $error("result lost between stages");

endmodule : broadcast_ring_multi_reader_core

`default_nettype wire

// ===== rtl/brmr_ram.sv =====
// ----------------------------------------------------------------------------
// brmr_ram: generic single-clock RAM
// One write port and one read port; read data is registered and holds its
// value while the read enable is low.
// ----------------------------------------------------------------------------
`default_nettype none

module brmr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule : brmr_ram

`default_nettype wire

// ===== rtl/brmr_ctrl.sv =====
// ----------------------------------------------------------------------------
// brmr_ctrl: write pointer, reader table and request decode
// Holds the write pointer, the per-reader pointers and flags and the id
// counter. Decides each request in the cycle it is accepted and drives the
// ring RAM ports.
// ----------------------------------------------------------------------------
`default_nettype none

module brmr_ctrl #(
    parameter int RING_DEPTH = 16
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_acc,
    input  wire brmr_pkg::t_op                 i_op,
    input  wire logic [brmr_pkg::RD_W-1:0]     i_reader,
    input  wire logic [brmr_pkg::DATA_W-1:0]   i_data,
    output logic                               o_wr_en,
    output logic [$clog2(RING_DEPTH)-1:0]      o_wr_addr,
    output logic [brmr_pkg::DATA_W-1:0]        o_wr_data,
    output logic                               o_rd_en,
    output logic [$clog2(RING_DEPTH)-1:0]      o_rd_addr,
    output brmr_pkg::t_res                     o_res
);

    import brmr_pkg::*;

    localparam int PTR_W = $clog2(RING_DEPTH);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(RING_DEPTH - 1);

    logic [PTR_W-1:0]    r_wp, n_wp;
    logic [PTR_W-1:0]    r_rpos [MAX_READERS];
    logic [PTR_W-1:0]    n_rpos [MAX_READERS];
    logic [MAX_READERS-1:0] r_active, n_active;
    logic [MAX_READERS-1:0] r_quit, n_quit;
    logic [ID_CNT_W-1:0] r_next_id, n_next_id;

    logic [PTR_W-1:0]       wp_inc;
    logic [MAX_READERS-1:0] hit;
    logic [DROP_W-1:0]      drop_cnt;
    logic [PTR_W-1:0]       sel_rpos;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        ptr_inc = (p == PTR_LAST) ? '0 : p + PTR_W'(1);
    endfunction

    // Readers that a write would overrun, and how many there are.
    always_comb begin
        wp_inc   = ptr_inc(r_wp);
        drop_cnt = '0;
        for (int i = 0; i < MAX_READERS; i++) begin
            hit[i]   = r_active[i] && (r_rpos[i] == wp_inc);
            drop_cnt = drop_cnt + DROP_W'(hit[i]);
        end
    end

    assign sel_rpos = r_rpos[i_reader];

    // Request decode and next state.
    always_comb begin
        n_wp      = r_wp;
        n_rpos    = r_rpos;
        n_active  = r_active;
        n_quit    = r_quit;
        n_next_id = r_next_id;
        o_wr_en   = 1'b0;
        o_rd_en   = 1'b0;
        o_res     = '{rd_hit: 1'b0, status: ST_OK, new_reader: '0, dropped: '0};
        unique case (i_op)
            OP_WRITE: begin
                o_wr_en       = i_acc;
                n_wp          = wp_inc;
                o_res.dropped = drop_cnt;
                for (int i = 0; i < MAX_READERS; i++) begin
                    if (hit[i]) begin
                        n_rpos[i] = ptr_inc(r_rpos[i]);
                    end
                end
            end
            OP_READ: begin
                if (!r_active[i_reader]) begin
                    o_res.status = ST_UNKNOWN;
                end else if (r_quit[i_reader]) begin
                    o_res.status = ST_QUIT;
                end else if (sel_rpos == r_wp) begin
                    o_res.status = ST_EMPTY;
                end else begin
                    o_res.rd_hit     = 1'b1;
                    o_rd_en          = i_acc;
                    n_rpos[i_reader] = ptr_inc(sel_rpos);
                end
            end
            OP_ADD: begin
                if (r_next_id >= ID_CNT_W'(MAX_READERS)) begin
                    o_res.status = ST_FULL;
                end else begin
                    o_res.new_reader                = r_next_id[RD_W-1:0];
                    n_active[r_next_id[RD_W-1:0]]   = 1'b1;
                    n_quit[r_next_id[RD_W-1:0]]     = 1'b0;
                    n_rpos[r_next_id[RD_W-1:0]]     = r_wp;
                    n_next_id                       = r_next_id + ID_CNT_W'(1);
                end
            end
            OP_QUIT: begin
                if (!r_active[i_reader]) begin
                    o_res.status = ST_UNKNOWN;
                end else begin
                    n_quit[i_reader] = 1'b1;
                end
            end
            default: begin
                o_res.status = ST_UNKNOWN;
            end
        endcase
    end

    // RAM addresses come straight from the pointers.
    assign o_wr_addr = r_wp;
    assign o_wr_data = i_data;
    assign o_rd_addr = sel_rpos;

    // State update on an accepted request.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp      <= '0;
            r_active  <= '0;
            r_quit    <= '0;
            r_next_id <= '0;
            for (int i = 0; i < MAX_READERS; i++) begin
                r_rpos[i] <= '0;
            end
        end else if (i_acc) begin
            r_wp      <= n_wp;
            r_rpos    <= n_rpos;
            r_active  <= n_active;
            r_quit    <= n_quit;
            r_next_id <= n_next_id;
        end
    end

    // Ids are handed out in order, so the active readers are exactly those
    // below the id counter.
    a_id_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_next_id <= ID_CNT_W'(MAX_READERS))
        else $error("reader id counter beyond table size");

    a_active_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(r_active) == int'(r_next_id))
        else $error("active readers disagree with id counter");

    // A write can only push readers that exist.
    a_drop_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_acc && i_op == OP_WRITE |-> int'(drop_cnt) <= $countones(r_active))
        else $error("push count exceeds active readers");

    // A ring read is never issued at the slot being written.
    a_no_rw_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rd_en |-> o_rd_addr != r_wp)
        else $error("ring read at write pointer");

endmodule : brmr_ctrl

`default_nettype wire
